FILE: src/hde_pkg.sv
// shared types, constants and the log table for the histogram divergence engine
// no dependencies; used by hde_serial_mul and histogram_divergence_engine
`default_nettype none

package hde_pkg;

  // log table size, a power of two
  localparam int LN_TABLE_ENTRIES = 256;
  localparam int LN_IDX_W = $clog2(LN_TABLE_ENTRIES);

  localparam int BIN_W   = 32;
  localparam int EPS_W   = 25;
  localparam int MODE_W  = 3;
  localparam int X_W     = 33;
  localparam int TAB_W   = 32;
  localparam int LN_W    = 38;
  localparam int LD_W    = 39;
  localparam int MUL_A_W = 37;
  localparam int MUL_B_W = 31 - LN_IDX_W;
  localparam int MUL_P_W = 64;
  localparam int MUL_CNT_W = 5;
  localparam int SUM_W   = 64;

  localparam logic [30:0] LN2_Q31 = 31'd1488522236;
  localparam logic signed [LN_W-1:0] LN2_X24 = 38'sd35724533664;
  localparam logic signed [SUM_W-1:0] TWO_LN2_Q40 = 64'sd1524246769572;

  localparam logic [MODE_W-1:0] MODE_ENTROPY = 3'd0;
  localparam logic [MODE_W-1:0] MODE_KL      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SYM     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_JS      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_IDIV    = 3'd4;

  localparam logic REG_MEASURE_MODE = 1'b0;
  localparam logic REG_EPSILON      = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LN_LOAD, ST_NORM, ST_LOOK, ST_INTERP, ST_MLO_GO, ST_MLO,
    ST_MHI_GO, ST_MHI, ST_ACC, ST_FIN, ST_SQRT, ST_OUT
  } hde_state_t;

  typedef struct packed {
    logic                 start;
    logic [MUL_A_W-1:0]   a;
    logic [MUL_B_W-1:0]   b;
    logic [MUL_CNT_W-1:0] nbits;
  } mul_req_t;

  typedef logic [LN_TABLE_ENTRIES:0][TAB_W-1:0] ln_tab_t;

  // restoring division, only used while the table is worked out
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo, r;
    int b;
    quo = 64'd0;
    r = 64'd0;
    for (b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // ln(1+i/N) in Q31 via the atanh series, worked out at elaboration
  function automatic ln_tab_t build_ln_tab();
    ln_tab_t tab;
    logic [63:0] y, y2, pw, acc, k, n;
    int i, j;
    n = 64'(LN_TABLE_ENTRIES);
    for (i = 0; i <= LN_TABLE_ENTRIES; i++) begin
      y = div_u64(64'(i) << 31, 2 * n + 64'(i));
      y2 = (y * y) >> 31;
      pw = y;
      acc = 64'd0;
      k = 64'd1;
      for (j = 0; j < 48; j++) begin
        if (pw != 64'd0) begin
          acc = acc + div_u64(pw, k);
          pw = (pw * y2) >> 31;
          k = k + 64'd2;
        end
      end
      tab[i] = TAB_W'(2 * acc);
    end
    return tab;
  endfunction

  localparam ln_tab_t LN_TAB = build_ln_tab();

endpackage

`default_nettype wire

FILE: src/histogram_divergence_engine.sv
// top level of the histogram divergence engine: sequencer, log, accumulate, finish
// depends on hde_pkg and hde_serial_mul
`default_nettype none

// One (p, q) bin pair is taken per item and one per-bin term of the measure
// chosen by measure_mode is added into a saturating Q23.40 sum. On the item
// with last_bin set the measure is finished (2 ln 2 added for symmetric KL,
// sqrt(sum/2) for Jensen-Shannon), handed out with its saturation flag and
// the sum is cleared. Items are worked one at a time. Each log is a bit-serial
// normalization, a table lookup and one serial multiply to interpolate; each
// x*ln product is two serial multiplies, by the low 16 and the high 17 bits
// of x. So an item costs roughly: entropy 1 ln + 1 product, standard KL and
// I-divergence 2 ln + 1 product, Jensen-Shannon 3 ln + 2 products, symmetric
// KL 3 ln + 3 products, plus accepting and accumulating; the whole is set by
// the one shared serial multiplier and the bit-serial normalizer. A last item
// adds the finish step, and the square root in Jensen-Shannon mode. The next
// item is accepted while a finished result waits in the output register; a
// last item waits for it. Configuration must be written through cfg_we /
// cfg_index / cfg_data only while idle; the block itself does not enforce this.
module histogram_divergence_engine (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [hde_pkg::EPS_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [hde_pkg::BIN_W-1:0]     p_bin,
  input  wire logic [hde_pkg::BIN_W-1:0]     q_bin,
  input  wire logic                          last_bin,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [hde_pkg::SUM_W-1:0]   measure_value,
  output logic                               saturated
);
  import hde_pkg::*;

  // configuration
  logic [MODE_W-1:0] measure_mode;
  logic [EPS_W-1:0]  epsilon;

  hde_state_t state, state_next;

  // per item operands and logs
  logic [MODE_W-1:0]            mode_r;
  logic                         last_r;
  logic [X_W-1:0]               xv [3];
  logic signed [LN_W-1:0]       lv [3];
  logic [2:0]                   ln_mask, mul_mask;
  logic [1:0]                   sel;
  logic signed [SUM_W-1:0]      term;

  // log unit
  logic [X_W-1:0]               nrm;
  logic [5:0]                   kcnt;
  logic [TAB_W-1:0]             lo;

  // product and accumulation
  logic [MUL_P_W-1:0]           plo;
  logic signed [SUM_W-1:0]      running_sum;
  logic                         overflow_seen;
  logic signed [SUM_W-1:0]      v_r;
  logic                         fclip;

  // square root
  logic [63:0]                  h_sh, rem, root;
  logic [5:0]                   sq_cnt;

  mul_req_t             mul_req;
  logic                 mul_done;
  logic [MUL_P_W-1:0]   mul_prod;

  hde_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .done    (mul_done),
    .product (mul_prod)
  );

  function automatic logic [SUM_W:0] sat_add(logic signed [SUM_W-1:0] a,
                                              logic signed [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? {1'b1, 1'b1, {(SUM_W-1){1'b0}}} : {1'b1, 1'b0, {(SUM_W-1){1'b1}}};
    end
    return {1'b0, s[SUM_W-1:0]};
  endfunction

  // ---- operand set-up for an incoming item
  logic [X_W-1:0] eps33, p33, q33, s33, m33;
  logic [X_W-1:0] in_x0, in_x1, in_x2;
  logic [2:0]     in_lnm, in_mm;
  logic signed [SUM_W-1:0] in_term, p_sh, q_sh;

  always_comb begin
    eps33 = (epsilon == '0) ? X_W'(1) : X_W'(epsilon);
    p33   = X_W'(p_bin);
    q33   = X_W'(q_bin);
    s33   = p33 + q33;
    m33   = {1'b0, s33[X_W-1:1]};
    p_sh  = SUM_W'({p_bin, 16'd0});
    q_sh  = SUM_W'({q_bin, 16'd0});
    in_x0 = (p33 == '0) ? eps33 : p33;
    in_x1 = (q33 == '0) ? eps33 : q33;
    in_x2 = (m33 == '0) ? eps33 : m33;
    in_lnm  = 3'b000;
    in_mm   = 3'b000;
    in_term = '0;
    case (measure_mode)
      MODE_ENTROPY: begin
        in_x0 = p33;
        if (p33 != '0) begin
          in_lnm = 3'b001;
          in_mm  = 3'b001;
        end
      end
      MODE_KL: begin
        in_lnm = 3'b011;
        in_mm  = 3'b001;
      end
      MODE_SYM: begin
        in_x0  = (p33 < eps33) ? eps33 : p33;
        in_x1  = (q33 < eps33) ? eps33 : q33;
        in_x2  = (s33 < eps33) ? eps33 : s33;
        in_lnm = 3'b111;
        in_mm  = 3'b111;
      end
      MODE_JS: begin
        in_lnm = 3'b111;
        in_mm  = 3'b011;
      end
      MODE_IDIV: begin
        if (p33 == '0) begin
          in_term = q_sh;
        end else begin
          in_term = q_sh - p_sh;
          in_lnm  = 3'b011;
          in_mm   = 3'b001;
        end
      end
      default: begin
        in_lnm = 3'b000;
      end
    endcase
  end

  // ---- log datapath: table lookup and exponent part
  logic [LN_IDX_W-1:0]     tab_idx;
  logic [TAB_W-1:0]        tab_lo, tab_hi, tab_diff;
  logic signed [LN_W-1:0]  ln_exp, ln_val;

  always_comb begin
    tab_idx  = nrm[31 -: LN_IDX_W];
    tab_lo   = LN_TAB[(LN_IDX_W+1)'(tab_idx)];
    tab_hi   = LN_TAB[(LN_IDX_W+1)'(tab_idx) + 1'b1];
    tab_diff = (tab_hi >= tab_lo) ? (tab_hi - tab_lo) : '0;
    ln_exp   = $signed({1'b0, 37'(kcnt) * 37'(LN2_Q31)}) - LN2_X24;
    ln_val   = ln_exp + $signed(LN_W'(lo))
             + $signed(LN_W'(mul_prod >> MUL_B_W));
  end

  // ---- x * ln operand for the current product
  logic signed [LD_W-1:0]  ld;
  logic [MUL_A_W-1:0]      mag;
  logic                    neg_term;
  logic [SUM_W-1:0]        r_prod;

  always_comb begin
    ld = LD_W'(lv[sel]);
    case (mode_r)
      MODE_KL, MODE_IDIV: ld = LD_W'(lv[0]) - LD_W'(lv[1]);
      MODE_JS:            ld = LD_W'(lv[sel]) - LD_W'(lv[2]);
      default:            ld = LD_W'(lv[sel]);
    endcase
    mag = ld[LD_W-1] ? MUL_A_W'(-ld) : MUL_A_W'(ld);
    // entropy negates, the s ln s part of symmetric KL is taken away
    neg_term = ld[LD_W-1] ^ ((mode_r == MODE_ENTROPY)
                             || (mode_r == MODE_SYM && sel == 2'd2));
    r_prod = (mul_prod << 1) + (plo >> 15);
  end

  // ---- sum, finishing and square root step
  logic [SUM_W:0] acc_res, fin_res;
  logic [63:0]    rem_sh, trial;
  logic           sq_ge;

  always_comb begin
    acc_res = sat_add(running_sum, term);
    fin_res = sat_add(running_sum, TWO_LN2_Q40);
    rem_sh  = {rem[61:0], h_sh[63:62]};
    trial   = {root[61:0], 2'b01};
    sq_ge   = (rem_sh >= trial);
  end

  logic ln_more, mul_more, out_free, sum_gt1;

  always_comb begin
    ln_more  = (sel == 2'd0) ? ln_mask[1] : ((sel == 2'd1) ? ln_mask[2] : 1'b0);
    mul_more = (sel == 2'd0) ? mul_mask[1] : ((sel == 2'd1) ? mul_mask[2] : 1'b0);
    out_free = !out_valid || !out_stall;
    sum_gt1  = (running_sum > 64'sd1);
  end

  // ---- next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_valid) state_next = (in_lnm != 3'b000) ? ST_LN_LOAD : ST_ACC;
      ST_LN_LOAD: state_next = ST_NORM;
      ST_NORM:    if (nrm[X_W-1]) state_next = ST_LOOK;
      ST_LOOK:    state_next = ST_INTERP;
      ST_INTERP:  if (mul_done) state_next = ln_more ? ST_LN_LOAD : ST_MLO_GO;
      ST_MLO_GO:  state_next = ST_MLO;
      ST_MLO:     if (mul_done) state_next = ST_MHI_GO;
      ST_MHI_GO:  state_next = ST_MHI;
      ST_MHI:     if (mul_done) state_next = mul_more ? ST_MLO_GO : ST_ACC;
      ST_ACC:     state_next = last_r ? ST_FIN : ST_IDLE;
      ST_FIN:     state_next = (mode_r == MODE_JS && sum_gt1) ? ST_SQRT : ST_OUT;
      ST_SQRT:    if (sq_cnt == 6'd1) state_next = ST_OUT;
      ST_OUT:     if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // ---- outputs of the sequencer
  always_comb begin
    in_stall      = rst || (state != ST_IDLE);
    mul_req.start = 1'b0;
    mul_req.a     = mag;
    mul_req.b     = MUL_B_W'(xv[sel][15:0]);
    mul_req.nbits = MUL_CNT_W'(16);
    case (state)
      ST_LOOK: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'(tab_diff);
        mul_req.b     = nrm[MUL_B_W:1];
        mul_req.nbits = MUL_CNT_W'(MUL_B_W);
      end
      ST_MLO_GO: begin
        mul_req.start = 1'b1;
      end
      ST_MHI_GO: begin
        mul_req.start = 1'b1;
        mul_req.b     = MUL_B_W'(xv[sel][X_W-1:16]);
        mul_req.nbits = MUL_CNT_W'(17);
      end
      default: begin
        mul_req.start = 1'b0;
      end
    endcase
  end

  // ---- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      measure_mode  <= MODE_KL;
      epsilon       <= EPS_W'(1);
      running_sum   <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
      sel           <= 2'd0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_MEASURE_MODE: measure_mode <= cfg_data[MODE_W-1:0];
          REG_EPSILON:      epsilon <= cfg_data;
          default:          epsilon <= epsilon;
        endcase
      end
      // result register: loaded from ST_OUT, emptied when taken
      if (state == ST_OUT && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            mode_r   <= measure_mode;
            last_r   <= last_bin;
            xv[0]    <= in_x0;
            xv[1]    <= in_x1;
            xv[2]    <= in_x2;
            ln_mask  <= in_lnm;
            mul_mask <= in_mm;
            term     <= in_term;
            sel      <= 2'd0;
          end
        end
        ST_LN_LOAD: begin
          nrm  <= (xv[sel] == '0) ? X_W'(1) : xv[sel];
          kcnt <= 6'd32;
        end
        ST_NORM: begin
          if (!nrm[X_W-1]) begin
            nrm  <= nrm << 1;
            kcnt <= kcnt - 1'b1;
          end
        end
        ST_LOOK: begin
          lo <= tab_lo;
        end
        ST_INTERP: begin
          if (mul_done) begin
            lv[sel] <= ln_val;
            sel     <= ln_more ? sel + 1'b1 : 2'd0;
          end
        end
        ST_MLO: begin
          if (mul_done) plo <= mul_prod;
        end
        ST_MHI: begin
          if (mul_done) begin
            term <= neg_term ? term - $signed(r_prod) : term + $signed(r_prod);
            if (mul_more) sel <= sel + 1'b1;
          end
        end
        ST_ACC: begin
          running_sum <= $signed(acc_res[SUM_W-1:0]);
          if (acc_res[SUM_W]) overflow_seen <= 1'b1;
        end
        ST_FIN: begin
          if (mode_r == MODE_SYM) begin
            v_r   <= $signed(fin_res[SUM_W-1:0]);
            fclip <= fin_res[SUM_W];
          end else begin
            fclip <= 1'b0;
            if (mode_r == MODE_JS) begin
              v_r    <= '0;
              h_sh   <= 64'(running_sum >>> 1);
              rem    <= '0;
              root   <= '0;
              sq_cnt <= 6'd52;
            end else begin
              v_r <= running_sum;
            end
          end
        end
        ST_SQRT: begin
          h_sh   <= h_sh << 2;
          sq_cnt <= sq_cnt - 1'b1;
          if (sq_ge) begin
            rem  <= rem_sh - trial;
            root <= {root[62:0], 1'b1};
            v_r  <= $signed({root[62:0], 1'b1});
          end else begin
            rem  <= rem_sh;
            root <= {root[62:0], 1'b0};
            v_r  <= $signed({root[62:0], 1'b0});
          end
        end
        ST_OUT: begin
          if (out_free) begin
            measure_value <= v_r;
            saturated     <= overflow_seen || fclip;
            running_sum   <= '0;
            overflow_seen <= 1'b0;
          end
        end
        default: begin
          sel <= sel;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_mul_done_waited: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_INTERP || state == ST_MLO || state == ST_MHI))
    else $error("multiplier finished outside a waiting state");
  a_norm_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_NORM |-> nrm != '0)
    else $error("normalizing a zero operand");
  a_out_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_valid && out_stall) |=> state == ST_OUT)
    else $error("result dropped over a waiting item");
  a_sel_range: assert property (@(posedge clk) disable iff (rst)
    sel != 2'd3)
    else $error("operand select out of range");
`endif

endmodule

`default_nettype wire

FILE: src/hde_serial_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on hde_pkg
`default_nettype none

module hde_serial_mul (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire hde_pkg::mul_req_t         req,
  output logic                           done,
  output logic [hde_pkg::MUL_P_W-1:0]    product
);
  import hde_pkg::*;

  logic                 busy;
  logic [MUL_P_W-1:0]   a_sh;
  logic [MUL_B_W-1:0]   b_sh;
  logic [MUL_CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && (cnt == MUL_CNT_W'(1));
      if (req.start) begin
        busy    <= 1'b1;
        a_sh    <= MUL_P_W'(req.a);
        b_sh    <= req.b;
        cnt     <= req.nbits;
        product <= '0;
      end else if (busy) begin
        if (b_sh[0]) product <= product + a_sh;
        a_sh <= a_sh << 1;
        b_sh <= b_sh >> 1;
        cnt  <= cnt - 1'b1;
        if (cnt == MUL_CNT_W'(1)) busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// self-checking testbench for histogram_divergence_engine
// depends on hde_pkg and the engine sources; runs a directed table then random bin streams
`timescale 1ns / 1ps

module testbench;
  import hde_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int ITEM_LATENCY = 800;   // worst item plus sqrt, with margin
  localparam int HOLD_CYCLES = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_MEASURE_MODE;
  logic [EPS_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [BIN_W-1:0] p_bin = '0;
  logic [BIN_W-1:0] q_bin = '0;
  logic last_bin = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SUM_W-1:0] measure_value;
  logic saturated;

  histogram_divergence_engine dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .p_bin(p_bin), .q_bin(q_bin), .last_bin(last_bin),
    .out_valid(out_valid), .out_stall(out_stall),
    .measure_value(measure_value), .saturated(saturated)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // expected measures, oldest first
  typedef struct {
    logic signed [SUM_W-1:0] value;
    logic                    sat;
  } measure_t;
  measure_t pending_measures[$];

  int fail_count = 0;
  int idle_in = 0;
  int idle_out = 0;
  bit hold_req = 0;
  int hold_cnt = 0;

  // directed rows may carry a typed-in expectation instead of the predicted one
  bit typed_on = 0;
  measure_t typed_measure;

  // ---------------- predictor ----------------
  logic [63:0] ln_frac_tab[0:LN_TABLE_ENTRIES];
  logic [MODE_W-1:0] cur_mode;
  logic [EPS_W-1:0] cur_eps;
  longint acc_sum;
  bit acc_clip;

  // ln(1+i/N) in Q31 by the atanh series
  task automatic fill_ln_table();
    logic [63:0] y, y2, pw, acc, k, n;
    n = 64'(LN_TABLE_ENTRIES);
    for (int i = 0; i <= LN_TABLE_ENTRIES; i++) begin
      y = (64'(i) << 31) / (2 * n + 64'(i));
      y2 = (y * y) >> 31;
      pw = y;
      acc = 0;
      k = 1;
      while (pw != 0) begin
        acc = acc + pw / k;
        pw = (pw * y2) >> 31;
        k = k + 2;
      end
      ln_frac_tab[i] = 2 * acc;
    end
  endtask

  // natural log of a Q8.24 value, signed Q31
  function automatic longint ln_fix(logic [63:0] x);
    int k;
    logic [63:0] t, m, f, prod, idx, rem, lo, hi, diff, lnf;
    if (x == 0) x = 1;
    k = 0;
    t = x;
    while (t > 1) begin
      t = t >> 1;
      k++;
    end
    m = (k <= 31) ? (x << (31 - k)) : (x >> (k - 31));
    f = m - (64'd1 << 31);
    prod = f * 64'(LN_TABLE_ENTRIES);
    idx = prod >> 31;
    if (idx >= 64'(LN_TABLE_ENTRIES)) idx = 64'(LN_TABLE_ENTRIES - 1);
    rem = prod & 64'h7FFF_FFFF;
    lo = ln_frac_tab[idx];
    hi = ln_frac_tab[idx + 1];
    diff = (hi >= lo) ? (hi - lo) : 64'd0;
    lnf = lo + ((diff * rem) >> 31);
    return longint'(k - 24) * 64'sd1488522236 + longint'(lnf);
  endfunction

  // Q8.24 times Q31 log, Q40 truncated toward zero
  function automatic longint x_times_ln(logic [63:0] x, longint l);
    logic [63:0] mag, r;
    mag = (l < 0) ? 64'(-l) : 64'(l);
    r = (((x >> 16) * mag) << 1) + (((x & 64'hFFFF) * mag) >> 15);
    return (l < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clip_add(longint a, longint b, inout bit clip);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      clip = 1;
      return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end
    return longint'(s[63:0]);
  endfunction

  function automatic longint kl_part(logic [63:0] a, logic [63:0] b, logic [63:0] eps);
    if (a == 0) a = eps;
    if (b == 0) b = eps;
    return x_times_ln(a, ln_fix(a) - ln_fix(b));
  endfunction

  function automatic logic [63:0] floor_at(logic [63:0] v, logic [63:0] lim);
    return (v < lim) ? lim : v;
  endfunction

  // floor(sqrt(h * 2^40))
  function automatic longint root_q40(logic [63:0] h);
    logic [63:0] rem, root, bits, trial;
    rem = 0;
    root = 0;
    for (int i = 51; i >= 0; i--) begin
      bits = (i >= 20) ? ((h >> (2 * (i - 20))) & 64'd3) : 64'd0;
      rem = (rem << 2) | bits;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return longint'(root);
  endfunction

  // adds one bin pair; returns 1 with the finished measure on the last bin
  function automatic bit accumulate_bin(logic [31:0] p32, logic [31:0] q32, logic last,
                                        output measure_t res);
    logic [63:0] p, q, eps, a, b, c, m, hm;
    longint term, v, h;
    bit clip, fclip;
    p = 64'(p32);
    q = 64'(q32);
    eps = (cur_eps == 0) ? 64'd1 : 64'(cur_eps);
    term = 0;
    clip = 0;
    fclip = 0;
    case (cur_mode)
      MODE_ENTROPY: if (p != 0) term = -x_times_ln(p, ln_fix(p));
      MODE_KL: term = kl_part(p, q, eps);
      MODE_SYM: begin
        a = floor_at(p, eps);
        b = floor_at(q, eps);
        c = floor_at(p + q, eps);
        term = x_times_ln(a, ln_fix(a)) + x_times_ln(b, ln_fix(b)) - x_times_ln(c, ln_fix(c));
      end
      MODE_JS: begin
        m = (p + q) >> 1;
        term = kl_part(p, m, eps) + kl_part(q, m, eps);
      end
      MODE_IDIV: begin
        if (p == 0) term = longint'(q << 16);
        else term = kl_part(p, q, eps) - longint'(p << 16) + longint'(q << 16);
      end
      default: term = 0;
    endcase
    acc_sum = clip_add(acc_sum, term, clip);
    if (clip) acc_clip = 1;
    res.value = 0;
    res.sat = 0;
    if (!last) return 0;
    v = acc_sum;
    if (cur_mode == MODE_SYM) begin
      v = clip_add(v, TWO_LN2_Q40, fclip);
    end else if (cur_mode == MODE_JS) begin
      if (v < 0) begin
        hm = (64'(-v) + 64'd1) >> 1;
        h = -longint'(hm);
      end else begin
        h = v >>> 1;
      end
      v = (h <= 0) ? 0 : root_q40(64'(h));
    end
    res.value = v;
    res.sat = acc_clip | fclip;
    acc_sum = 0;
    acc_clip = 0;
    return 1;
  endfunction

  // ---------------- monitor: config, accepted items, results ----------------
  always @(posedge clk) begin
    measure_t res, want;
    if (!rst) begin
      if (cfg_we) begin
        if (cfg_index == REG_MEASURE_MODE) cur_mode = cfg_data[MODE_W-1:0];
        else cur_eps = cfg_data;
      end
      if (in_valid && !in_stall) begin
        if (accumulate_bin(p_bin, q_bin, last_bin, res))
          pending_measures.push_back(typed_on ? typed_measure : res);
      end
      if (out_valid && !out_stall) begin
        if (pending_measures.size() == 0) begin
          $error("result with nothing expected: measure_value %0d", measure_value);
          fail_count++;
        end else begin
          want = pending_measures.pop_front();
          if (measure_value !== want.value) begin
            $error("measure_value expected %0d actual %0d", want.value, measure_value);
            fail_count++;
          end
          if (saturated !== want.sat) begin
            $error("saturated expected %0d actual %0d", want.sat, saturated);
            fail_count++;
          end
        end
      end
    end
  end

  // ---------------- receiver: random stall, plus a long hold-off ----------------
  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt = HOLD_CYCLES;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_out);
    end
  end

  // ---------------- sender tasks (called at a falling edge) ----------------
  task automatic send_bin(logic [31:0] p, logic [31:0] q, logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_in) gap++;
    if (gap > 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    p_bin <= p;
    q_bin <= q;
    last_bin <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // drop valid, wait for every expected measure, then let the block settle
  task automatic drain(int extra);
    if (in_valid) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    while (pending_measures.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // both registers are written each time
  task automatic write_regs(logic [MODE_W-1:0] mode, logic [EPS_W-1:0] eps);
    cfg_we <= 1'b1;
    cfg_index <= REG_MEASURE_MODE;
    cfg_data <= EPS_W'(mode);
    @(negedge clk);
    cfg_index <= REG_EPSILON;
    cfg_data <= eps;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_bin(logic [EPS_W-1:0] eps);
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'($urandom_range(1, 255));
      2: return 32'(eps) + 32'($urandom_range(0, 2));
      3: return 32'hFFFF_FFFF;
      4: return 32'h0100_0000 + 32'($urandom_range(0, 4096)) - 32'd2048;
      5: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [EPS_W-1:0] pick_eps();
    case ($urandom_range(5))
      0: return '0;
      1: return 25'd1;
      2: return 25'd16777216;
      default: return 25'($urandom_range(1, 16777216));
    endcase
  endfunction

  // ---------------- directed table ----------------
  typedef struct {
    bit                      set_regs;
    logic [MODE_W-1:0]       mode;
    logic [EPS_W-1:0]        eps;
    logic [31:0]             p;
    logic [31:0]             q;
    logic                    last;
    bit                      typed;
    logic signed [SUM_W-1:0] value;
    logic                    sat;
  } row_t;
  row_t rows[$];

  localparam logic [31:0] ONE = 32'h0100_0000;
  localparam logic [31:0] MAX = 32'hFFFF_FFFF;

  initial begin
    int cnt, len;
    bit paused;
    logic [MODE_W-1:0] mode;
    logic [EPS_W-1:0] eps;

    fill_ln_table();
    cur_mode = MODE_KL;     // reset values
    cur_eps = 25'd1;
    acc_sum = 0;
    acc_clip = 0;

    // reset values in force: standard KL, epsilon 1
    rows.push_back('{0, MODE_KL, 1, ONE, ONE, 1, 1, 0, 0});
    rows.push_back('{0, MODE_KL, 1, 0, 0, 1, 1, 0, 0});        // both empty -> epsilon
    rows.push_back('{0, MODE_KL, 1, MAX, 0, 1, 0, 0, 0});
    rows.push_back('{0, MODE_KL, 1, 0, MAX, 1, 0, 0, 0});
    rows.push_back('{0, MODE_KL, 1, 1, MAX, 0, 0, 0, 0});
    rows.push_back('{0, MODE_KL, 1, MAX, 1, 1, 0, 0, 0});
    rows.push_back('{1, MODE_ENTROPY, 1, ONE, MAX, 1, 1, 0, 0});
    rows.push_back('{0, MODE_ENTROPY, 1, 0, MAX, 1, 1, 0, 0}); // empty bin skipped
    rows.push_back('{0, MODE_ENTROPY, 1, MAX, 0, 1, 0, 0, 0});
    rows.push_back('{0, MODE_ENTROPY, 1, 1, 0, 1, 0, 0, 0});
    // symmetric: everything clamped to 1.0, only 2 ln 2 remains
    rows.push_back('{1, MODE_SYM, 25'd16777216, 0, 0, 1, 1, TWO_LN2_Q40, 0});
    rows.push_back('{0, MODE_SYM, 25'd16777216, MAX, MAX, 1, 0, 0, 0});
    // epsilon zero acts as one
    rows.push_back('{1, MODE_JS, 0, 5, 5, 1, 1, 0, 0});
    rows.push_back('{0, MODE_JS, 0, MAX, 0, 1, 0, 0, 0});
    rows.push_back('{0, MODE_JS, 0, 0, 0, 1, 1, 0, 0});        // zero sum gives zero
    rows.push_back('{1, MODE_IDIV, 25'd1000, 0, 0, 1, 1, 0, 0});
    rows.push_back('{0, MODE_IDIV, 25'd1000, 0, MAX, 1, 0, 0, 0});
    rows.push_back('{0, MODE_IDIV, 25'd1000, MAX, 0, 1, 0, 0, 0});
    // unused mode adds nothing
    rows.push_back('{1, 3'd7, 25'd16777216, MAX, 1, 1, 1, 0, 0});
    rows.push_back('{1, 3'd5, 25'd33, 12345, 678, 0, 0, 0, 0});
    rows.push_back('{0, 3'd6, 25'd33, 1, 2, 1, 1, 0, 0});

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    idle_in = 26;
    idle_out = 56;
    foreach (rows[i]) begin
      if (rows[i].set_regs) begin
        drain(ITEM_LATENCY);
        write_regs(rows[i].mode, rows[i].eps);
      end
      typed_on = rows[i].typed;
      typed_measure.value = rows[i].value;
      typed_measure.sat = rows[i].sat;
      send_bin(rows[i].p, rows[i].q, rows[i].last);
    end
    typed_on = 0;

    // mode change mid-stream keeps the running sum
    drain(ITEM_LATENCY);
    write_regs(MODE_KL, 25'd7);
    send_bin(32'h0200_0000, 32'h0080_0000, 1'b0);
    send_bin(MAX, 32'd3, 1'b0);
    drain(ITEM_LATENCY);
    write_regs(MODE_IDIV, 25'd16777216);
    send_bin(32'd0, 32'h0300_0000, 1'b1);

    // random streams over three idle settings
    for (int s = 0; s < 3; s++) begin
      idle_in = (s == 0) ? 26 : (s == 1) ? 56 : 0;
      idle_out = (s == 0) ? 56 : (s == 1) ? 26 : 0;
      for (int ph = 0; ph < 14; ph++) begin
        drain(ITEM_LATENCY);
        mode = ($urandom_range(9) < 8) ? MODE_W'($urandom_range(0, 4))
                                        : MODE_W'($urandom_range(5, 7));
        eps = pick_eps();
        write_regs(mode, eps);
        if (s == 0 && ph == 3) hold_req = 1;   // receiver stalls long, input backs up
        cnt = 0;
        paused = 0;
        while (cnt < 30) begin
          len = ($urandom_range(3) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 4);
          for (int j = 0; j < len; j++) begin
            send_bin(pick_bin(eps), pick_bin(eps), j == len - 1);
            cnt++;
          end
          if (s == 1 && ph == 5 && !paused && cnt >= 15) begin
            drain(0);    // sender waits for every expected measure
            paused = 1;
          end
        end
      end
    end

    drain(0);
    repeat (ITEM_LATENCY) @(posedge clk);
    if (pending_measures.size() != 0) begin
      $error("%0d expected measures never arrived", pending_measures.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("** histogram_divergence_engine: PASSED **");
    end else begin
      $display("** histogram_divergence_engine: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(60_000_000);
    $display("** histogram_divergence_engine: FAILED **");
    $finish;
  end

endmodule
